@@ rtl/sfr_pkg.sv @@
// Shared types and constants for the stuffed frame receiver.
// Holds the word structs, op and status codes and register map; no dependencies.
package sfr_pkg;

  localparam int unsigned BufDepthDefault = 256;

  // Register map: byte address 4*i, decoded on paddr[3:2]
  localparam int unsigned PaddrWidth = 4;
  localparam logic [1:0] RegStartByte    = 2'd0;
  localparam logic [1:0] RegExtLenEnable = 2'd1;
  localparam logic [1:0] RegExtLenMarker = 2'd2;

  localparam logic [7:0] StartByteReset = 8'h00;
  localparam logic [7:0] MarkerReset    = 8'hFF;

  // Op codes of an input word
  localparam logic [1:0] OpPush    = 2'd0;
  localparam logic [1:0] OpRead    = 2'd1;
  localparam logic [1:0] OpRelease = 2'd2;

  // Status codes of a result word
  localparam logic [1:0] StatIdle   = 2'd0;
  localparam logic [1:0] StatBusy   = 2'd1;
  localparam logic [1:0] StatHeld   = 2'd2;
  localparam logic [1:0] StatLenErr = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } sfr_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] frame_length;
    logic [7:0] read_data;
    logic       byte_dropped;
  } sfr_out_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic       ext_len_enable;
    logic [7:0] ext_len_marker;
  } sfr_cfg_t;

endpackage

@@ rtl/sfr_regs.sv @@
// Configuration registers of the stuffed frame receiver behind an APB-style port.
// Depends on sfr_pkg for the register map and the configuration struct.
module sfr_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfr_pkg::PaddrWidth-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output sfr_pkg::sfr_cfg_t                cfg_o
);

  sfr_pkg::sfr_cfg_t cfg_q;
  logic              wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte     <= sfr_pkg::StartByteReset;
      cfg_q.ext_len_enable <= 1'b0;
      cfg_q.ext_len_marker <= sfr_pkg::MarkerReset;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        sfr_pkg::RegStartByte:    cfg_q.start_byte     <= pwdata[7:0];
        sfr_pkg::RegExtLenEnable: cfg_q.ext_len_enable <= pwdata[0];
        sfr_pkg::RegExtLenMarker: cfg_q.ext_len_marker <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sfr_pkg::RegStartByte:    prdata = {24'h000000, cfg_q.start_byte};
      sfr_pkg::RegExtLenEnable: prdata = {31'h00000000, cfg_q.ext_len_enable};
      sfr_pkg::RegExtLenMarker: prdata = {24'h000000, cfg_q.ext_len_marker};
      default:                  prdata = 32'h00000000;
    endcase
  end

endmodule

@@ rtl/sfr_buf.sv @@
// Frame buffer memory: one write port, one read port, registered read data.
// No dependencies; sized by the BufDepth parameter from the top level.
module sfr_buf #(
  parameter int unsigned BufDepth = 256,
  localparam int unsigned AddrW = (BufDepth > 1) ? $clog2(BufDepth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [BufDepth];
  logic [7:0] rdata_q;

  // Write and read are both issued at the accept edge of their own word,
  // so a read always sees every earlier write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sfr_ctrl.sv @@
// Receive state machine: escape handling, length parsing, frame hold and buffer access.
// Depends on sfr_pkg for codes and word structs; drives the sfr_buf ports.
module sfr_ctrl #(
  parameter int unsigned BufDepth = 256,
  localparam int unsigned AddrW = (BufDepth > 1) ? $clog2(BufDepth) : 1,
  localparam int unsigned PosW  = $clog2(BufDepth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfr_pkg::sfr_cfg_t cfg_i,
  input  logic              accept_i,
  input  sfr_pkg::sfr_in_t  in_word_i,
  output logic              mem_we_o,
  output logic [AddrW-1:0]  mem_waddr_o,
  output logic [7:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [AddrW-1:0]  mem_raddr_o,
  output logic              res_valid_o,
  output sfr_pkg::sfr_out_t res_word_o,
  output logic              res_rd_sel_o
);

  typedef enum logic [2:0] {
    PhLen,
    PhLenLow,
    PhLenHigh,
    PhData,
    PhErr,
    PhDone
  } phase_e;

  phase_e            phase_q, phase_d, phase_sel;
  logic              esc_q, esc_d;
  logic [15:0]       exp_q, exp_d;
  logic [PosW-1:0]   wp_q, wp_d, wp_inc;
  logic [PosW-1:0]   held_q, held_d;
  logic              res_valid_q;
  sfr_pkg::sfr_out_t res_word_q, res_word_d;
  logic              res_rd_sel_q;

  logic        take, new_frame, dropped, rd_hit, wr_hit, check;
  logic [7:0]  ch;
  logic [1:0]  status;

  assign ch        = in_word_i.rx_byte;
  assign phase_sel = new_frame ? PhLen : phase_q;
  assign wp_inc    = wp_q + PosW'(1);

  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    exp_d     = exp_q;
    wp_d      = wp_q;
    held_d    = held_q;
    take      = 1'b0;
    new_frame = 1'b0;
    dropped   = 1'b0;
    rd_hit    = 1'b0;
    wr_hit    = 1'b0;
    check     = 1'b0;

    if (accept_i) begin
      case (in_word_i.op)
        sfr_pkg::OpPush: begin
          if (held_q != '0) begin
            dropped = 1'b1;
          end else if (esc_q) begin
            // Doubled start byte is a literal, anything else opens a frame
            take      = 1'b1;
            new_frame = (ch != cfg_i.start_byte);
            esc_d     = 1'b0;
          end else if (ch == cfg_i.start_byte) begin
            esc_d = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
        sfr_pkg::OpRead: begin
          rd_hit = ({24'h000000, in_word_i.read_index} < 32'(BufDepth));
        end
        sfr_pkg::OpRelease: begin
          held_d = '0;
        end
        default: ;
      endcase
    end

    if (take) begin
      if (new_frame) begin
        wp_d = '0;
      end
      unique case (phase_sel)
        PhLen: begin
          // Marker test first, even when marker equals start byte
          if (cfg_i.ext_len_enable && ch == cfg_i.ext_len_marker) begin
            phase_d = PhLenLow;
          end else begin
            exp_d = (ch > cfg_i.start_byte) ? {8'h00, ch - 8'd1} : {8'h00, ch};
            check = 1'b1;
          end
        end
        PhLenLow: begin
          exp_d   = {8'h00, ch};
          phase_d = PhLenHigh;
        end
        PhLenHigh: begin
          exp_d = exp_q | {ch, 8'h00};
          check = 1'b1;
        end
        PhData: begin
          wr_hit = ({1'b0, wp_q} < (PosW + 1)'(BufDepth));
          wp_d   = wp_inc;
          if (17'(wp_inc) >= {1'b0, exp_q}) begin
            held_d  = exp_q[PosW-1:0];
            phase_d = PhDone;
          end
        end
        default: ;
      endcase
      if (check) begin
        wp_d    = '0;
        phase_d = (exp_d == 16'h0000 || {1'b0, exp_d} > 17'(BufDepth)) ? PhErr : PhData;
      end
    end
  end

  always_comb begin
    if (held_d != '0) begin
      status = sfr_pkg::StatHeld;
    end else if (phase_d == PhErr) begin
      status = sfr_pkg::StatLenErr;
    end else if (phase_d == PhLenLow || phase_d == PhLenHigh || phase_d == PhData) begin
      status = sfr_pkg::StatBusy;
    end else begin
      status = sfr_pkg::StatIdle;
    end
    res_word_d.status       = status;
    res_word_d.frame_length = 9'(held_d);
    res_word_d.read_data    = 8'h00;
    res_word_d.byte_dropped = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhLen;
      esc_q        <= 1'b0;
      exp_q        <= '0;
      wp_q         <= '0;
      held_q       <= '0;
      res_valid_q  <= 1'b0;
      res_rd_sel_q <= 1'b0;
      res_word_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      esc_q       <= esc_d;
      exp_q       <= exp_d;
      wp_q        <= wp_d;
      held_q      <= held_d;
      res_valid_q <= accept_i;
      if (accept_i) begin
        res_word_q   <= res_word_d;
        res_rd_sel_q <= rd_hit;
      end
    end
  end

  assign mem_we_o     = wr_hit;
  assign mem_waddr_o  = AddrW'(wp_q);
  assign mem_wdata_o  = ch;
  assign mem_re_o     = rd_hit;
  assign mem_raddr_o  = AddrW'(in_word_i.read_index);
  assign res_valid_o  = res_valid_q;
  assign res_word_o   = res_word_q;
  assign res_rd_sel_o = res_rd_sel_q;

endmodule

@@ rtl/sfr_outq.sv @@
// Two-entry result queue: merges buffer read data into the result word and
// decouples the output handshake. Depends on sfr_pkg for the result struct.
module sfr_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfr_pkg::sfr_out_t push_word_i,
  input  logic              rd_sel_i,
  input  logic [7:0]        rdata_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sfr_pkg::sfr_out_t out_word_o
);

  sfr_pkg::sfr_out_t fifo_q [2];
  sfr_pkg::sfr_out_t merged;
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic [2:0]        occ;
  logic              pop;

  always_comb begin
    merged           = push_word_i;
    merged.read_data = rd_sel_i ? rdata_i : 8'h00;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Count the word in flight so the queue never overflows
  assign occ    = 3'(cnt_q) + 3'(push_i) - 3'(pop);
  assign room_o = (occ < 3'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= merged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= 2'(occ);
    end
  end

endmodule

@@ rtl/stuffed_frame_receiver_top.sv @@
// Stuffed frame receiver, top level. Latency: the accept edge updates state and reads
// the buffer; the next edge puts the result word in the queue and raises out_valid_o.
// Throughput: one word per cycle while the queue has room, set by the single buffer
// port pair and result queue. Reset clears control state and configuration; the
// frame buffer is not cleared and needs no clearing pass, so words are accepted
// right after reset. Depends on sfr_pkg, sfr_regs, sfr_buf, sfr_ctrl and sfr_outq.
module stuffed_frame_receiver_top #(
  parameter int unsigned BufDepth = sfr_pkg::BufDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sfr_pkg::sfr_in_t               in_word_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sfr_pkg::sfr_out_t              out_word_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfr_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned AddrW = (BufDepth > 1) ? $clog2(BufDepth) : 1;

  sfr_pkg::sfr_cfg_t cfg;
  logic              accept;
  logic              room;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  logic              res_valid;
  sfr_pkg::sfr_out_t res_word;
  logic              res_rd_sel;

  // Take a word whenever the result queue can absorb it, including while a
  // finished result still waits at the output.
  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  sfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // State machine updates all control state at the accept edge and issues
  // the buffer write (push) or read (read op) at that same edge.
  sfr_ctrl #(
    .BufDepth (BufDepth)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .in_word_i    (in_word_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .res_valid_o  (res_valid),
    .res_word_o   (res_word),
    .res_rd_sel_o (res_rd_sel)
  );

  sfr_buf #(
    .BufDepth (BufDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Merge the registered read data and hold results until taken.
  sfr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_word_i (res_word),
    .rd_sel_i    (res_rd_sel),
    .rdata_i     (mem_rdata),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ sim/tb_stuffed_frame_receiver_top.sv @@
// Self-checking testbench for stuffed_frame_receiver_top: byte stuffing, length prefixes,
// held frames, buffer reads and the register port under several idling mixes.
// Depends on sfr_pkg and the receiver RTL; needs no files or arguments.
module tb_stuffed_frame_receiver_top;

  // Codes the package leaves out: the unused op and the unused register slot
  localparam logic [1:0] OpSpare  = 2'd3;
  localparam logic [1:0] RegSpare = 2'd3;

  typedef enum logic [2:0] {
    PhLen, PhLenLow, PhLenHigh, PhData, PhErr, PhDone
  } rx_phase_e;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  sfr_pkg::sfr_in_t               in_word_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  sfr_pkg::sfr_out_t              out_word_o;
  logic                           psel        = 1'b0;
  logic                           penable     = 1'b0;
  logic                           pwrite      = 1'b0;
  logic [sfr_pkg::PaddrWidth-1:0] paddr       = '0;
  logic [31:0]                    pwdata      = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  // Idling knobs, in percent of cycles
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  // Mirror of the receiver: configuration, framing state and buffer image
  logic [7:0]  cfg_start   = sfr_pkg::StartByteReset;
  logic        cfg_ext_en  = 1'b0;
  logic [7:0]  cfg_marker  = sfr_pkg::MarkerReset;
  rx_phase_e   ph          = PhLen;
  logic        esc_pending = 1'b0;
  logic [15:0] want_len    = '0;
  logic [8:0]  wpos        = '0;
  logic [8:0]  held_len    = '0;
  logic [7:0]  frame_mem [256];
  bit          mem_written [256];
  int unsigned written_cnt = 0;

  // Results still owed by the receiver, oldest first
  sfr_pkg::sfr_out_t due_results [$];

  int unsigned words_sent       = 0;
  int unsigned results_seen     = 0;
  int unsigned mismatches       = 0;
  int unsigned frames_done      = 0;
  int unsigned len_errors       = 0;
  int unsigned drops            = 0;
  int unsigned settings_applied = 0;

  stuffed_frame_receiver_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result side at the current rate; a rate of zero keeps it always ready
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at result %0d: %s, got %0h, want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Check a freshly assembled length: start the payload or flag a length error
  task automatic arm_length();
    wpos = '0;
    ph   = PhData;
    if (want_len == 16'd0 || want_len > 16'(sfr_pkg::BufDepthDefault)) begin
      ph = PhErr;
      len_errors++;
    end
  endtask

  // Advance the framing state by one de-stuffed byte
  task automatic feed_byte(input logic [7:0] ch, input bit new_frame);
    if (new_frame) begin
      wpos = '0;
      ph   = PhLen;
    end
    case (ph)
      PhLen: begin
        if (cfg_ext_en && ch == cfg_marker) begin
          ph = PhLenLow;
        end else begin
          // a length byte above the start value was shifted up by one on the line
          want_len = (ch > cfg_start) ? 16'(ch - 8'd1) : 16'(ch);
          arm_length();
        end
      end
      PhLenLow: begin
        want_len = {8'h00, ch};
        ph       = PhLenHigh;
      end
      PhLenHigh: begin
        want_len[15:8] = ch;
        arm_length();
      end
      PhData: begin
        frame_mem[wpos[7:0]] = ch;
        if (!mem_written[wpos[7:0]]) begin
          mem_written[wpos[7:0]] = 1'b1;
          written_cnt++;
        end
        wpos++;
        if (16'(wpos) >= want_len) begin
          held_len = want_len[8:0];
          ph       = PhDone;
          frames_done++;
        end
      end
      default: ;
    endcase
  endtask

  // Work out the result word of one accepted input word and queue it
  task automatic predict_result(input sfr_pkg::sfr_in_t w);
    sfr_pkg::sfr_out_t r;
    r = '0;
    case (w.op)
      sfr_pkg::OpPush: begin
        if (held_len != '0) begin
          // a held frame swallows the byte and leaves the escape flag alone
          r.byte_dropped = 1'b1;
          drops++;
        end else if (esc_pending) begin
          feed_byte(w.rx_byte, w.rx_byte != cfg_start);
          esc_pending = 1'b0;
        end else if (w.rx_byte == cfg_start) begin
          esc_pending = 1'b1;
        end else begin
          feed_byte(w.rx_byte, 1'b0);
        end
      end
      sfr_pkg::OpRead:    r.read_data = frame_mem[w.read_index];
      sfr_pkg::OpRelease: held_len = '0;
      default: ;
    endcase
    if (held_len != '0) begin
      r.status = sfr_pkg::StatHeld;
    end else if (ph == PhErr) begin
      r.status = sfr_pkg::StatLenErr;
    end else if (ph == PhLenLow || ph == PhLenHigh || ph == PhData) begin
      r.status = sfr_pkg::StatBusy;
    end else begin
      r.status = sfr_pkg::StatIdle;
    end
    r.frame_length = held_len;
    due_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: compare every accepted result word with the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    sfr_pkg::sfr_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        report_mismatch("result word with none owed", 32'(out_word_o), 32'd0);
      end else begin
        want = due_results.pop_front();
        if (out_word_o.status !== want.status)
          report_mismatch("status", 32'(out_word_o.status), 32'(want.status));
        if (out_word_o.frame_length !== want.frame_length)
          report_mismatch("frame_length", 32'(out_word_o.frame_length),
                          32'(want.frame_length));
        if (out_word_o.read_data !== want.read_data)
          report_mismatch("read_data", 32'(out_word_o.read_data), 32'(want.read_data));
        if (out_word_o.byte_dropped !== want.byte_dropped)
          report_mismatch("byte_dropped", 32'(out_word_o.byte_dropped),
                          32'(want.byte_dropped));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Every task here is entered right after a rising edge.
  // ---------------------------------------------------------------------------

  // Send one word: idle at the current gap rate, raise valid, hold until accepted
  task automatic send_word(input logic [1:0] op, input logic [7:0] rx, input logic [7:0] idx);
    sfr_pkg::sfr_in_t w;
    w.op         = op;
    w.rx_byte    = rx;
    w.read_index = idx;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_result(w);
    words_sent++;
  endtask

  task automatic push_raw(input logic [7:0] b);
    send_word(sfr_pkg::OpPush, b, 8'($urandom));
  endtask

  // Push a byte as content: double it when it collides with the start value
  task automatic push_lit(input logic [7:0] b);
    if (b == cfg_start) push_raw(b);
    push_raw(b);
  endtask

  task automatic release_frame();
    send_word(sfr_pkg::OpRelease, 8'($urandom), 8'($urandom));
  endtask

  // Read a buffer entry that has been written, leaning toward the two ends
  task automatic read_entry();
    logic [7:0] idx;
    if (written_cnt == 0) return;
    case ($urandom_range(3))
      0:       idx = 8'h00;
      1:       idx = 8'hFF;
      default: idx = 8'($urandom);
    endcase
    while (!mem_written[idx]) idx++;
    send_word(sfr_pkg::OpRead, 8'($urandom), idx);
  endtask

  function automatic bit wide_len_ok();
    return cfg_ext_en && (cfg_marker != cfg_start);
  endfunction

  // Encode a length after a start byte: one shifted byte, or marker plus 16 bits
  task automatic send_length(input logic [15:0] len);
    logic [7:0] b;
    bit         use_wide;
    b        = (len < 16'(cfg_start)) ? len[7:0] : 8'(len + 16'd1);
    use_wide = wide_len_ok() && (len > 16'd254 || b == cfg_marker || $urandom_range(3) == 0);
    if (use_wide) begin
      push_raw(cfg_marker);
      push_lit(len[7:0]);
      push_lit(len[15:8]);
    end else begin
      push_raw(b);
    end
  endtask

  // Start a frame of the given length and push some of its payload
  task automatic send_frame(input logic [15:0] len, input int unsigned n_payload);
    push_raw(cfg_start);
    send_length(len);
    repeat (n_payload) push_lit(8'($urandom));
  endtask

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return 16'($urandom_range(8, 1));
    if (r < 95) return 16'($urandom_range(40, 9));
    if (r < 99) return 16'($urandom_range(254, 41));
    return wide_len_ok() ? 16'($urandom_range(256, 255)) : 16'd254;
  endfunction

  // Drop valid and wait until every owed result has come back, then a short pause
  task automatic settle();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (due_results.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (due_results.size() != 0)
      report_mismatch("results never arrived", 32'(due_results.size()), 32'd0);
    // a result passes the control registers and the result queue before it leaves
    repeat (4) @(posedge clk_i);
  endtask

  // One register write: setup cycle, then access cycle held until pready, then idle
  task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      sfr_pkg::RegStartByte:    cfg_start  = value;
      sfr_pkg::RegExtLenEnable: cfg_ext_en = value[0];
      sfr_pkg::RegExtLenMarker: cfg_marker = value;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [7:0] start, input logic en, input logic [7:0] marker);
    settle();
    reg_write(sfr_pkg::RegStartByte, start);
    reg_write(sfr_pkg::RegExtLenEnable, {7'h0, en});
    reg_write(sfr_pkg::RegExtLenMarker, marker);
    settings_applied++;
  endtask

  // Mostly well-formed frames with random content, mixed with aborted frames,
  // bad lengths and loose noise words
  task automatic run_traffic(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned pick;
    logic [15:0] len;
    logic [1:0]  op;
    stop_at = words_sent + n_words;
    release_frame();
    if (wide_len_ok()) begin
      // one full-buffer frame per wide-length setting writes every entry
      send_frame(16'd256, 256);
      read_entry();
      read_entry();
      release_frame();
    end
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = pick_length();
        send_frame(len, 32'(len));
        repeat ($urandom_range(3)) read_entry();
        if ($urandom_range(4) == 0) repeat ($urandom_range(2, 1)) push_raw(8'($urandom));
        if ($urandom_range(9) != 0) release_frame();
      end else if (pick < 80) begin
        // cut the payload short; the next start byte begins a fresh frame
        len = pick_length();
        send_frame(len, $urandom_range(int'(len) - 1));
      end else if (pick < 88) begin
        push_raw(cfg_start);
        if (wide_len_ok() && $urandom_range(1) == 0) begin
          send_length($urandom_range(1) ? 16'($urandom_range(65535, 257)) : 16'd0);
        end else begin
          send_length(16'd0);
        end
        repeat ($urandom_range(3)) push_raw(8'($urandom));
      end else begin
        repeat ($urandom_range(4, 1)) begin
          op = 2'($urandom_range(3));
          if (op == sfr_pkg::OpRead && written_cnt != 0) begin
            read_entry();
          end else begin
            send_word((op == sfr_pkg::OpRead) ? sfr_pkg::OpRelease : op,
                      8'($urandom), 8'($urandom));
          end
        end
      end
    end
    release_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the receiver waits for a length byte. With the marker equal
  // to the start value, a doubled start byte there announces a 16-bit length.
  task automatic test_boot_marker_is_start();
    apply_config(8'h7E, 1'b1, 8'h7E);
    push_raw(8'h7E);
    push_raw(8'h7E);
    push_raw(8'h02);
    push_raw(8'h00);
    push_lit(8'h7E);                       // stuffed literal start value
    push_raw(8'hFF);                       // completes the frame, now held
    push_raw(8'h00);                       // dropped while held
    send_word(sfr_pkg::OpRead, 8'hFF, 8'h00);
    send_word(sfr_pkg::OpRead, 8'h00, 8'h01);
    send_word(OpSpare, 8'hFF, 8'hFF);      // unused op: reports only
    release_frame();
    release_frame();                       // nothing held: no effect
  endtask

  // Zero length, bytes ignored in the error phase, a stuffed zero in a short frame
  task automatic test_short_lengths();
    apply_config(8'h00, 1'b0, 8'hFF);
    push_raw(8'h00);
    push_raw(8'h01);                       // shifted down to zero: length error
    push_raw(8'h05);
    push_raw(8'h00);
    push_raw(8'h00);                       // literal start in error phase: ignored
    push_raw(8'h00);
    push_raw(8'h03);                       // length two
    push_raw(8'hAA);
    push_lit(8'h00);
    send_word(sfr_pkg::OpRead, 8'hFF, 8'h01);
    release_frame();
  endtask

  // A 16-bit length one beyond the buffer
  task automatic test_wide_length_limit();
    apply_config(8'hFF, 1'b1, 8'h00);
    push_raw(8'hFF);
    push_raw(8'h00);
    push_raw(8'h01);
    push_raw(8'h01);
  endtask

  task automatic test_traffic_no_idle();
    gap_pct   = 0;
    stall_pct = 0;
    apply_config(8'h7E, 1'b1, 8'h7D);
    run_traffic(440);
  endtask

  task automatic test_traffic_sender_gaps();
    gap_pct   = 53;
    stall_pct = 0;
    apply_config(8'hFF, 1'b0, 8'h00);
    run_traffic(440);
  endtask

  task automatic test_traffic_receiver_stalls();
    gap_pct   = 0;
    stall_pct = 53;
    apply_config(8'h00, 1'b1, 8'hFF);
    run_traffic(440);
  endtask

  task automatic test_traffic_both_idle();
    logic [7:0] start;
    logic [7:0] marker;
    gap_pct   = 20;
    stall_pct = 20;
    start = 8'($urandom);
    do marker = 8'($urandom); while (marker == start);
    apply_config(start, 1'b1, marker);
    // a write past the register list must change nothing
    reg_write(RegSpare, 8'($urandom));
    run_traffic(440);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boot_marker_is_start();
    test_short_lengths();
    test_wide_length_limit();
    test_traffic_no_idle();
    test_traffic_sender_gaps();
    test_traffic_receiver_stalls();
    test_traffic_both_idle();
    settle();
    $display("covered %0d input words and %0d result words over %0d register settings",
             words_sent, results_seen, settings_applied);
    $display("frames held %0d, length errors %0d, bytes dropped while held %0d",
             frames_done, len_errors, drops);
    if (mismatches == 0) begin
      $display("[stuffed_frame_receiver_top] OK");
    end else begin
      $display("[stuffed_frame_receiver_top] ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #3000000;
    $display("[stuffed_frame_receiver_top] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/sfr_pkg.sv
rtl/sfr_regs.sv
rtl/sfr_buf.sv
rtl/sfr_ctrl.sv
rtl/sfr_outq.sv
rtl/stuffed_frame_receiver_top.sv
sim/tb_stuffed_frame_receiver_top.sv
